### rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the pose covariance conjugation block
// Holds the micro-command format passed from the sequencer to the datapath,
// the operand source and destination codes, and small arithmetic helpers.
// ----------------------------------------------------------------------------
package pcc_pkg;

    // Fixed formats
    localparam int WORD_W     = 32;
    localparam int QUAT_FRAC  = 30;
    localparam int COV_DIM    = 6;
    localparam int COV_N      = 36;
    localparam int COV_AW     = 6;

    // Input item kinds (carried on the slave-side tuser)
    localparam logic [1:0] OP_ORIG  = 2'd0;
    localparam logic [1:0] OP_CONJ  = 2'd1;
    localparam logic [1:0] OP_SHIFT = 2'd2;
    localparam logic [1:0] OP_COV   = 2'd3;

    // Quaternion component positions
    localparam logic [1:0] Q_W = 2'd0;
    localparam logic [1:0] Q_X = 2'd1;
    localparam logic [1:0] Q_Y = 2'd2;
    localparam logic [1:0] Q_Z = 2'd3;

    // Quaternion selector
    localparam logic [2:0] QSEL_ORIG = 3'd0;
    localparam logic [2:0] QSEL_CONJ = 3'd1;

    // Sources for the first multiplier operand
    localparam logic [1:0] ASRC_QA  = 2'd0;
    localparam logic [1:0] ASRC_RO  = 2'd1;
    localparam logic [1:0] ASRC_JAC = 2'd2;

    // Sources for the second multiplier operand
    localparam logic [2:0] BSRC_QB    = 3'd0;
    localparam logic [2:0] BSRC_SHIFT = 3'd1;
    localparam logic [2:0] BSRC_U     = 3'd2;
    localparam logic [2:0] BSRC_SKEW  = 3'd3;
    localparam logic [2:0] BSRC_COV   = 3'd4;
    localparam logic [2:0] BSRC_T     = 3'd5;

    // Rounding shift applied to each product
    localparam logic [1:0] SHF_ROT  = 2'd0;
    localparam logic [1:0] SHF_QUAT = 2'd1;
    localparam logic [1:0] SHF_COV  = 2'd2;

    // Write-back destinations
    localparam logic [2:0] DST_RC  = 3'd0;
    localparam logic [2:0] DST_RO  = 3'd1;
    localparam logic [2:0] DST_U   = 3'd2;
    localparam logic [2:0] DST_W   = 3'd3;
    localparam logic [2:0] DST_BM  = 3'd4;
    localparam logic [2:0] DST_T   = 3'd5;
    localparam logic [2:0] DST_OUT = 3'd6;

    // One multiply-accumulate step
    typedef struct packed {
        logic       valid;
        logic [1:0] a_src;
        logic [2:0] a_r;
        logic [2:0] a_c;
        logic [2:0] b_src;
        logic [2:0] b_r;
        logic [2:0] b_c;
        logic [1:0] shf;
        logic       sub;
        logic       first;
        logic       init_one;
        logic       last;
        logic [2:0] dst;
        logic [2:0] d_r;
        logic [2:0] d_c;
    } t_cmd;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic pipe_empty;
        logic out_busy;
    } t_dp_stat;

    // One term of a rotation matrix entry
    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ib;
        logic       sub;
    } t_rot_term;

    // Terms of the quaternion to rotation matrix formula, two per entry.
    function automatic t_rot_term rot_term(input logic [1:0] i, input logic [1:0] j,
                                           input logic k);
        t_rot_term t;
        t = '0;
        case ({i, j})
            4'b0000: t = k ? t_rot_term'{Q_Z, Q_Z, 1'b1} : t_rot_term'{Q_Y, Q_Y, 1'b1};
            4'b0001: t = k ? t_rot_term'{Q_W, Q_Z, 1'b1} : t_rot_term'{Q_X, Q_Y, 1'b0};
            4'b0010: t = k ? t_rot_term'{Q_W, Q_Y, 1'b0} : t_rot_term'{Q_X, Q_Z, 1'b0};
            4'b0100: t = k ? t_rot_term'{Q_W, Q_Z, 1'b0} : t_rot_term'{Q_X, Q_Y, 1'b0};
            4'b0101: t = k ? t_rot_term'{Q_Z, Q_Z, 1'b1} : t_rot_term'{Q_X, Q_X, 1'b1};
            4'b0110: t = k ? t_rot_term'{Q_W, Q_X, 1'b1} : t_rot_term'{Q_Y, Q_Z, 1'b0};
            4'b1000: t = k ? t_rot_term'{Q_W, Q_Y, 1'b1} : t_rot_term'{Q_X, Q_Z, 1'b0};
            4'b1001: t = k ? t_rot_term'{Q_W, Q_X, 1'b0} : t_rot_term'{Q_Y, Q_Z, 1'b0};
            4'b1010: t = k ? t_rot_term'{Q_Y, Q_Y, 1'b1} : t_rot_term'{Q_X, Q_X, 1'b1};
            default: t = '0;
        endcase
        return t;
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Row-major position in the 6x6 store.
    function automatic logic [COV_AW-1:0] flat6(input logic [2:0] r, input logic [2:0] c);
        return ({3'b000, r} << 2) + ({3'b000, r} << 1) + {3'b000, c};
    endfunction

    // Row-major position in a 3x3 block.
    function automatic logic [3:0] flat3(input logic [1:0] r, input logic [1:0] c);
        return ({2'b00, r} << 1) + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

### rtl/core/pose_covariance_conjugation.sv
// Load items (quaternions, translation, covariance elements) are taken one per
// cycle while the block is idle. The covariance item flagged last starts a run
// that builds both rotation matrices, the lever-arm vector, the Jacobian and
// J*C*J^T on a single shared 32x33 multiply-accumulate pipeline, one product
// per cycle except while the pipeline drains between phases or an output
// element waits for the result slot. The input channel is held off for the
// whole run; the 36 results leave row-major with tlast on element (5,5).
// ----------------------------------------------------------------------------
// pose_covariance_conjugation: 6x6 pose covariance propagation
// Top level joining the sequencer, the datapath and the stream interfaces.
// ----------------------------------------------------------------------------
module pose_covariance_conjugation #(
    parameter int COV_FRAC_BITS = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // row[2:0], col[5:3], v0, v1, v2, v3, zero pad
    input  logic [1:0]   s_axis_tuser,  // opcode[1:0]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], zero pad
    output logic         m_axis_tlast
);

    pcc_pkg::t_cmd     w_cmd;
    pcc_pkg::t_dp_stat w_stat;
    logic              w_load;
    logic              w_start;
    logic [2:0]        w_out_row;
    logic [2:0]        w_out_col;
    logic signed [31:0] w_out_value;

    // Input request decode.
    assign w_load  = s_axis_tvalid && s_axis_tready;
    assign w_start = w_load && (s_axis_tuser == pcc_pkg::OP_COV) && s_axis_tlast;

    pcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_ready (s_axis_tready)
    );

    pcc_dp #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_load      (w_load),
        .i_opcode    (s_axis_tuser),
        .i_row       (s_axis_tdata[2:0]),
        .i_col       (s_axis_tdata[5:3]),
        .i_v0        ($signed(s_axis_tdata[37:6])),
        .i_v1        ($signed(s_axis_tdata[69:38])),
        .i_v2        ($signed(s_axis_tdata[101:70])),
        .i_v3        ($signed(s_axis_tdata[133:102])),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_row   (w_out_row),
        .o_out_col   (w_out_col),
        .o_out_value (w_out_value),
        .o_out_last  (m_axis_tlast),
        .o_stat      (w_stat)
    );

    // Output request packing.
    assign m_axis_tdata = {2'b00, w_out_value, w_out_col, w_out_row};

`ifndef SYNTHESIS
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> w_stat.pipe_empty)
        else $error("input taken while the pipeline still holds work");

    a_start_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !s_axis_tready)
        else $error("input not held off after the run started");

    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.valid |-> !s_axis_tready)
        else $error("command issued while the input side is open");
`endif

endmodule

### rtl/core/pcc_ram.sv
// ----------------------------------------------------------------------------
// pcc_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl: sequencer for the covariance conjugation
// Walks the computation phases, draining the pipeline between them, and issues
// one multiply-accumulate command per cycle to the datapath if output is free.
// ----------------------------------------------------------------------------
module pcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pcc_pkg::t_dp_stat i_stat,
    output pcc_pkg::t_cmd     o_cmd,
    output logic              o_ready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RC    = 4'd1;
    localparam logic [3:0] S_RO    = 4'd2;
    localparam logic [3:0] S_U     = 4'd3;
    localparam logic [3:0] S_W     = 4'd4;
    localparam logic [3:0] S_B     = 4'd5;
    localparam logic [3:0] S_T     = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;

    logic [3:0] r_state, n_state;
    logic [3:0] r_after, n_after;
    logic [2:0] r_i, n_i;
    logic [2:0] r_j, n_j;
    logic [3:0] r_k, n_k;

    logic [2:0] imax, jmax;
    logic [3:0] kmax;
    logic [3:0] next_phase;
    logic       busy_phase;
    logic       issue;
    logic [2:0] kk;
    pcc_pkg::t_rot_term rt;
    pcc_pkg::t_cmd      cmd;

    // Loop bounds and successor of each phase.
    always_comb begin
        imax       = 3'd2;
        jmax       = 3'd2;
        kmax       = 4'd2;
        next_phase = S_IDLE;
        busy_phase = 1'b1;
        case (r_state)
            S_RC: begin
                kmax = 4'd1;  next_phase = S_RO;
            end
            S_RO: begin
                kmax = 4'd1;  next_phase = S_U;
            end
            S_U: begin
                jmax = 3'd0;  next_phase = S_W;
            end
            S_W: begin
                jmax = 3'd0;  next_phase = S_B;
            end
            S_B: begin
                next_phase = S_T;
            end
            S_T: begin
                imax = 3'd5;  jmax = 3'd5;  kmax = 4'd5;  next_phase = S_OUT;
            end
            S_OUT: begin
                imax = 3'd5;  jmax = 3'd5;  kmax = 4'd11; next_phase = S_IDLE;
            end
            default: begin
                busy_phase = 1'b0;
            end
        endcase
    end

    // An output element starts only once the result slot is free.
    assign issue = busy_phase && !((r_state == S_OUT) && (r_k == 4'd0) && i_stat.out_busy);
    assign kk    = (r_k >= 4'd6) ? 3'(r_k - 4'd6) : r_k[2:0];
    assign rt    = pcc_pkg::rot_term(r_i[1:0], r_j[1:0], r_k[0]);

    // Command for the current step.
    always_comb begin
        cmd       = '0;
        cmd.valid = issue;
        cmd.shf   = pcc_pkg::SHF_QUAT;
        cmd.first = (r_k == 4'd0);
        cmd.last  = (r_k == kmax);
        cmd.d_r   = r_i;
        cmd.d_c   = r_j;
        case (r_state)
            S_RC, S_RO: begin
                cmd.a_src    = pcc_pkg::ASRC_QA;
                cmd.a_r      = (r_state == S_RC) ? pcc_pkg::QSEL_CONJ : pcc_pkg::QSEL_ORIG;
                cmd.a_c      = {1'b0, rt.ia};
                cmd.b_src    = pcc_pkg::BSRC_QB;
                cmd.b_r      = cmd.a_r;
                cmd.b_c      = {1'b0, rt.ib};
                cmd.shf      = pcc_pkg::SHF_ROT;
                cmd.sub      = rt.sub;
                cmd.init_one = (r_i == r_j);
                cmd.dst      = (r_state == S_RC) ? pcc_pkg::DST_RC : pcc_pkg::DST_RO;
            end
            S_U: begin
                cmd.a_src = pcc_pkg::ASRC_JAC;
                cmd.a_r   = r_k[2:0];
                cmd.a_c   = r_i;
                cmd.b_src = pcc_pkg::BSRC_SHIFT;
                cmd.b_c   = r_k[2:0];
                cmd.dst   = pcc_pkg::DST_U;
                cmd.d_c   = r_i;
            end
            S_W: begin
                cmd.a_src = pcc_pkg::ASRC_RO;
                cmd.a_r   = r_i;
                cmd.a_c   = r_k[2:0];
                cmd.b_src = pcc_pkg::BSRC_U;
                cmd.b_c   = r_k[2:0];
                cmd.dst   = pcc_pkg::DST_W;
                cmd.d_c   = r_i;
            end
            S_B: begin
                cmd.a_src = pcc_pkg::ASRC_JAC;
                cmd.a_r   = r_i;
                cmd.a_c   = r_k[2:0];
                cmd.b_src = pcc_pkg::BSRC_SKEW;
                cmd.b_r   = r_k[2:0];
                cmd.b_c   = r_j;
                cmd.dst   = pcc_pkg::DST_BM;
            end
            S_T: begin
                cmd.a_src = pcc_pkg::ASRC_JAC;
                cmd.a_r   = r_i;
                cmd.a_c   = r_k[2:0];
                cmd.b_src = pcc_pkg::BSRC_COV;
                cmd.b_r   = r_k[2:0];
                cmd.b_c   = r_j;
                cmd.shf   = (r_i < 3'd3 && r_k >= 4'd3) ? pcc_pkg::SHF_COV : pcc_pkg::SHF_QUAT;
                cmd.dst   = pcc_pkg::DST_T;
            end
            S_OUT: begin
                // First half sums S(i,j), second half S(j,i).
                cmd.a_src = pcc_pkg::ASRC_JAC;
                cmd.b_src = pcc_pkg::BSRC_T;
                cmd.a_c   = kk;
                cmd.b_c   = kk;
                if (r_k < 4'd6) begin
                    cmd.a_r = r_j;
                    cmd.b_r = r_i;
                    cmd.shf = (r_j < 3'd3 && kk >= 3'd3) ? pcc_pkg::SHF_COV : pcc_pkg::SHF_QUAT;
                end else begin
                    cmd.a_r = r_i;
                    cmd.b_r = r_j;
                    cmd.shf = (r_i < 3'd3 && kk >= 3'd3) ? pcc_pkg::SHF_COV : pcc_pkg::SHF_QUAT;
                end
                cmd.dst = pcc_pkg::DST_OUT;
            end
            default: begin
                cmd.valid = 1'b0;
            end
        endcase
    end

    // Phase and loop counter sequencing.
    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RC;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = r_after;
                end
            end
            default: begin
                if (issue) begin
                    if (r_k == kmax) begin
                        n_k = '0;
                        if (r_j == jmax) begin
                            n_j = '0;
                            if (r_i == imax) begin
                                n_i     = '0;
                                n_state = S_DRAIN;
                                n_after = next_phase;
                            end else begin
                                n_i = r_i + 3'd1;
                            end
                        end else begin
                            n_j = r_j + 3'd1;
                        end
                    end else begin
                        n_k = r_k + 4'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_cmd   = cmd;
    assign o_ready = (r_state == S_IDLE);

endmodule

### rtl/core/pcc_dp.sv
// ----------------------------------------------------------------------------
// pcc_dp: datapath for the covariance conjugation
// Operand stores, a four-stage multiply-accumulate pipeline with rounding
// shifts, the covariance and product memories, and the result register.
// ----------------------------------------------------------------------------
module pcc_dp #(
    parameter int COV_FRAC_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pcc_pkg::t_cmd            i_cmd,
    input  logic                     i_load,
    input  logic [1:0]               i_opcode,
    input  logic [2:0]               i_row,
    input  logic [2:0]               i_col,
    input  logic signed [31:0]       i_v0,
    input  logic signed [31:0]       i_v1,
    input  logic signed [31:0]       i_v2,
    input  logic signed [31:0]       i_v3,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [2:0]               o_out_row,
    output logic [2:0]               o_out_col,
    output logic signed [31:0]       o_out_value,
    output logic                     o_out_last,
    output pcc_pkg::t_dp_stat        o_stat
);

    // Operand stores
    logic signed [31:0] r_qa [8];
    logic signed [31:0] r_qb [8];
    logic signed [31:0] r_ts [3];
    logic signed [31:0] r_rc [9];
    logic signed [31:0] r_ro [9];
    logic signed [31:0] r_u  [3];
    logic signed [31:0] r_w  [3];
    logic signed [31:0] r_bm [9];
    logic [pcc_pkg::COV_N-1:0] r_cov_vld;

    // Pipeline registers
    pcc_pkg::t_cmd      r_c1, r_c2, r_c3;
    logic               r_hit;
    logic signed [31:0] r_opa;
    logic signed [32:0] r_opb;
    logic signed [64:0] r_prod;
    logic signed [63:0] r_acc, n_acc;

    // Result register
    logic               r_out_valid;
    logic [2:0]         r_out_row;
    logic [2:0]         r_out_col;
    logic signed [31:0] r_out_value;
    logic               r_out_last;

    logic                          cov_we;
    logic [pcc_pkg::COV_AW-1:0]    cov_waddr;
    logic [pcc_pkg::COV_AW-1:0]    rd_addr;
    logic [31:0]                   cov_rdata;
    logic [31:0]                   t_rdata;
    logic                          t_we;
    logic                          wb;
    logic signed [31:0]            opa, wb_val, out_val;
    logic signed [32:0]            opb;
    logic [1:0]                    jr, jc;
    logic                          j_rhi, j_chi;
    logic [1:0]                    sk_idx;
    logic                          sk_neg, sk_zero;
    logic signed [65:0]            pe, r29, r30, rcov;
    logic signed [63:0]            term, base;
    logic signed [64:0]            half;

    // Operand loads from the input channel.
    assign cov_we    = i_load && (i_opcode == pcc_pkg::OP_COV) && (i_row < 3'd6)
                       && (i_col < 3'd6);
    assign cov_waddr = pcc_pkg::flat6(i_row, i_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 8; n++) begin
                r_qa[n] <= '0;
                r_qb[n] <= '0;
            end
            for (int n = 0; n < 3; n++) begin
                r_ts[n] <= '0;
            end
            r_cov_vld <= '0;
        end else if (i_load) begin
            case (i_opcode)
                pcc_pkg::OP_ORIG: begin
                    r_qa[0] <= i_v0; r_qa[1] <= i_v1; r_qa[2] <= i_v2; r_qa[3] <= i_v3;
                    r_qb[0] <= i_v0; r_qb[1] <= i_v1; r_qb[2] <= i_v2; r_qb[3] <= i_v3;
                end
                pcc_pkg::OP_CONJ: begin
                    r_qa[4] <= i_v0; r_qa[5] <= i_v1; r_qa[6] <= i_v2; r_qa[7] <= i_v3;
                    r_qb[4] <= i_v0; r_qb[5] <= i_v1; r_qb[6] <= i_v2; r_qb[7] <= i_v3;
                end
                pcc_pkg::OP_SHIFT: begin
                    r_ts[0] <= i_v0; r_ts[1] <= i_v1; r_ts[2] <= i_v2;
                end
                default: begin
                    if (cov_we) begin
                        r_cov_vld[cov_waddr] <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Memories: the covariance store and the intermediate product J*C.
    assign rd_addr = pcc_pkg::flat6(i_cmd.b_r, i_cmd.b_c);
    assign wb      = r_c3.valid && r_c3.last;
    assign t_we    = wb && (r_c3.dst == pcc_pkg::DST_T);

    pcc_ram #(.WIDTH(32), .DEPTH(pcc_pkg::COV_N)) u_cov_ram (
        .i_clk   (i_clk),
        .i_we    (cov_we),
        .i_waddr (cov_waddr),
        .i_wdata (i_v0),
        .i_raddr (rd_addr),
        .o_rdata (cov_rdata)
    );

    pcc_ram #(.WIDTH(32), .DEPTH(pcc_pkg::COV_N)) u_t_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (pcc_pkg::flat6(r_c3.d_r, r_c3.d_c)),
        .i_wdata (wb_val),
        .i_raddr (rd_addr),
        .o_rdata (t_rdata)
    );

    // Stage one: command registered while the memories are read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
        end else begin
            r_c1 <= i_cmd;
        end
        r_hit <= r_cov_vld[rd_addr];
    end

    // Jacobian entry: rotation blocks on the diagonal, R*skew(w) upper right.
    assign j_rhi = (r_c1.a_r >= 3'd3);
    assign j_chi = (r_c1.a_c >= 3'd3);
    assign jr    = j_rhi ? 2'(r_c1.a_r - 3'd3) : r_c1.a_r[1:0];
    assign jc    = j_chi ? 2'(r_c1.a_c - 3'd3) : r_c1.a_c[1:0];

    // Skew-symmetric matrix of w, addressed as (row, column).
    always_comb begin
        sk_idx  = 2'd0;
        sk_neg  = 1'b0;
        sk_zero = 1'b0;
        case ({r_c1.b_r[1:0], r_c1.b_c[1:0]})
            4'b0001: begin sk_idx = 2'd2; sk_neg = 1'b1; end
            4'b0010: begin sk_idx = 2'd1; end
            4'b0100: begin sk_idx = 2'd2; end
            4'b0110: begin sk_idx = 2'd0; sk_neg = 1'b1; end
            4'b1000: begin sk_idx = 2'd1; sk_neg = 1'b1; end
            4'b1001: begin sk_idx = 2'd0; end
            default: begin sk_zero = 1'b1; end
        endcase
    end

    // First operand selection.
    always_comb begin
        case (r_c1.a_src)
            pcc_pkg::ASRC_QA:  opa = r_qa[{r_c1.a_r[0], r_c1.a_c[1:0]}];
            pcc_pkg::ASRC_RO:  opa = r_ro[pcc_pkg::flat3(r_c1.a_r[1:0], r_c1.a_c[1:0])];
            pcc_pkg::ASRC_JAC: begin
                if (!j_rhi && j_chi) begin
                    opa = r_bm[pcc_pkg::flat3(jr, jc)];
                end else if (j_rhi == j_chi) begin
                    opa = r_rc[pcc_pkg::flat3(jr, jc)];
                end else begin
                    opa = '0;
                end
            end
            default: opa = '0;
        endcase
    end

    // Second operand selection, one bit wider to hold a negated word.
    always_comb begin
        case (r_c1.b_src)
            pcc_pkg::BSRC_QB:    opb = 33'(r_qb[{r_c1.b_r[0], r_c1.b_c[1:0]}]);
            pcc_pkg::BSRC_SHIFT: opb = 33'(r_ts[r_c1.b_c[1:0]]);
            pcc_pkg::BSRC_U:     opb = 33'(r_u[r_c1.b_c[1:0]]);
            pcc_pkg::BSRC_SKEW: begin
                if (sk_zero) begin
                    opb = '0;
                end else if (sk_neg) begin
                    opb = -33'(r_w[sk_idx]);
                end else begin
                    opb = 33'(r_w[sk_idx]);
                end
            end
            pcc_pkg::BSRC_COV:   opb = r_hit ? 33'($signed(cov_rdata)) : '0;
            pcc_pkg::BSRC_T:     opb = 33'($signed(t_rdata));
            default:             opb = '0;
        endcase
    end

    // Stages two and three: operand registers, then the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2 <= '0;
            r_c3 <= '0;
        end else begin
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
        r_opa  <= opa;
        r_opb  <= opb;
        r_prod <= r_opa * r_opb;
    end

    // Stage four: round-to-nearest shift and accumulate.
    assign pe   = 66'(r_prod);
    assign r29  = (pe + (66'sd1 <<< (pcc_pkg::QUAT_FRAC - 2))) >>> (pcc_pkg::QUAT_FRAC - 1);
    assign r30  = (pe + (66'sd1 <<< (pcc_pkg::QUAT_FRAC - 1))) >>> pcc_pkg::QUAT_FRAC;
    assign rcov = (pe + (66'sd1 <<< (COV_FRAC_BITS - 1))) >>> COV_FRAC_BITS;

    always_comb begin
        case (r_c3.shf)
            pcc_pkg::SHF_ROT: term = 64'(r29);
            pcc_pkg::SHF_COV: term = 64'(rcov);
            default:          term = 64'(r30);
        endcase
        if (r_c3.first) begin
            base = r_c3.init_one ? (64'sd1 <<< pcc_pkg::QUAT_FRAC) : 64'sd0;
        end else begin
            base = r_acc;
        end
        n_acc = r_c3.sub ? (base - term) : (base + term);
    end

    assign wb_val  = pcc_pkg::sat32(n_acc);
    assign half    = (65'(n_acc) + 65'sd1) >>> 1;
    assign out_val = pcc_pkg::sat32($signed(half[63:0]));

    always_ff @(posedge i_clk) begin
        if (r_c3.valid) begin
            r_acc <= n_acc;
        end
    end

    // Write-back of finished sums to the small operand stores.
    always_ff @(posedge i_clk) begin
        if (wb) begin
            case (r_c3.dst)
                pcc_pkg::DST_RC: r_rc[pcc_pkg::flat3(r_c3.d_r[1:0], r_c3.d_c[1:0])] <= wb_val;
                pcc_pkg::DST_RO: r_ro[pcc_pkg::flat3(r_c3.d_r[1:0], r_c3.d_c[1:0])] <= wb_val;
                pcc_pkg::DST_U:  r_u[r_c3.d_c[1:0]] <= wb_val;
                pcc_pkg::DST_W:  r_w[r_c3.d_c[1:0]] <= wb_val;
                pcc_pkg::DST_BM: r_bm[pcc_pkg::flat3(r_c3.d_r[1:0], r_c3.d_c[1:0])] <= wb_val;
                default: ;
            endcase
        end
    end

    // Result register towards the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb && (r_c3.dst == pcc_pkg::DST_OUT)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (wb && (r_c3.dst == pcc_pkg::DST_OUT)) begin
            r_out_row   <= r_c3.d_r;
            r_out_col   <= r_c3.d_c;
            r_out_value <= out_val;
            r_out_last  <= (r_c3.d_r == 3'd5) && (r_c3.d_c == 3'd5);
        end
    end

    // Status for the sequencer.
    assign o_stat.pipe_empty = !(r_c1.valid || r_c2.valid || r_c3.valid);
    assign o_stat.out_busy   = r_out_valid
        || (r_c1.valid && r_c1.last && (r_c1.dst == pcc_pkg::DST_OUT))
        || (r_c2.valid && r_c2.last && (r_c2.dst == pcc_pkg::DST_OUT))
        || (r_c3.valid && r_c3.last && (r_c3.dst == pcc_pkg::DST_OUT));

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule
